### rtl/core/rbi_pkg.sv
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types and constants of the ray / box intersection pipeline.
// ----------------------------------------------------------------------------
package rbi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int LANES         = 3;
	// quotient bits below the saturation bit
	localparam int DIV_STAGES    = 31;
	// setup stage, saturation check stage, one stage per quotient bit
	localparam int LANE_LAT      = DIV_STAGES + 2;
	localparam int MERGE_LAT     = 2;

	typedef logic signed [31:0] fix_t;

	// what one axis lane hands to the merging stage
	typedef struct packed {
		logic        cand;   // origin outside the slab on this axis
		logic        pos;    // distance is non-negative
		logic        ovf;    // distance saturates
		logic [30:0] q;      // distance magnitude
		logic [31:0] plane;
		logic [31:0] org;
		logic [31:0] dir;
		logic [31:0] lo;
		logic [31:0] hi;
	} lane_res_t;

endpackage

### rtl/core/ray_box_intersection.sv
// ----------------------------------------------------------------------------
// ray_box_intersection
// Ray against axis-aligned box, three axis lanes and a merging stage.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  request | in        | in_valid / in_stall  | origin_*, direction_*, box_min_*, box_max_*
//  result  | out       | out_valid / out_stall| hit, hit_x, hit_y, hit_z
//
// One request per cycle while in_stall is low; a 33-stage divider per lane (setup,
// saturation check, one quotient bit per stage), two merging stages and the output register.
// Reset clears only the valid chain and the output valid.
// The whole pipeline holds while a result waits under out_stall; a request
// is still taken in that case when the output register is empty.
// ----------------------------------------------------------------------------
module ray_box_intersection import rbi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  fix_t origin_x,
	input  fix_t origin_y,
	input  fix_t origin_z,
	input  fix_t direction_x,
	input  fix_t direction_y,
	input  fix_t direction_z,
	input  fix_t box_min_x,
	input  fix_t box_min_y,
	input  fix_t box_min_z,
	input  fix_t box_max_x,
	input  fix_t box_max_y,
	input  fix_t box_max_z,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output fix_t hit_x,
	output fix_t hit_y,
	output fix_t hit_z
);

	localparam int LAT = LANE_LAT + MERGE_LAT;

	logic      en;
	logic      vld_q [LAT];
	logic      out_valid_q;
	lane_res_t lane [LANES];

	assign en        = !out_valid_q || !out_stall;
	assign in_stall  = !en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[LAT-1];
		end
	end

	rbi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
		.clk(clk), .en(en), .org(origin_x), .dir(direction_x),
		.lo(box_min_x), .hi(box_max_x), .res(lane[0])
	);
	rbi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
		.clk(clk), .en(en), .org(origin_y), .dir(direction_y),
		.lo(box_min_y), .hi(box_max_y), .res(lane[1])
	);
	rbi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
		.clk(clk), .en(en), .org(origin_z), .dir(direction_z),
		.lo(box_min_z), .hi(box_max_z), .res(lane[2])
	);

	rbi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk(clk), .en(en), .lane(lane),
		.hit(hit), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
	);

endmodule

### rtl/core/rbi_lane.sv
// ----------------------------------------------------------------------------
// rbi_lane
// One axis: candidate plane, then a pipelined restoring divider giving the
// parametric distance to that plane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbi_lane import rbi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      en,
	input  fix_t      org,
	input  fix_t      dir,
	input  fix_t      lo,
	input  fix_t      hi,
	output lane_res_t res
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int NS = LANE_LAT;

	logic [NW-1:0] rem_s [NS];
	logic [31:0]   den_s [NS];
	logic [30:0]   quo_s [NS];
	lane_res_t     pay_s [NS];

	logic        lt, gt;
	logic [31:0] plane;
	logic [32:0] diff, mag;
	logic [31:0] dneg;
	lane_res_t   pay0;
	lane_res_t   pay1;

	always_comb begin
		lt    = $signed(org) < $signed(lo);
		gt    = !lt && ($signed(org) > $signed(hi));
		plane = lt ? lo : hi;
		diff  = {plane[31], plane} - {org[31], org};
		mag   = diff[32] ? (33'd0 - diff) : diff;
		dneg  = 32'd0 - dir;
		pay0       = '0;
		pay0.cand  = lt || gt;
		pay0.pos   = (lt && !dir[31] && (dir != 32'd0)) || (gt && dir[31]);
		pay0.plane = plane;
		pay0.org   = org;
		pay0.dir   = dir;
		pay0.lo    = lo;
		pay0.hi    = hi;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {mag[31:0], {FRAC_BITS{1'b0}}};
			den_s[0] <= dir[31] ? dneg : dir;
			quo_s[0] <= '0;
			pay_s[0] <= pay0;
		end
	end

	// saturation check: quotient of 2^31 or more
	always_comb begin
		pay1     = pay_s[0];
		pay1.ovf = {{(64-NW){1'b0}}, rem_s[0]} >= {1'b0, den_s[0], 31'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[1] <= rem_s[0];
			den_s[1] <= den_s[0];
			quo_s[1] <= quo_s[0];
			pay_s[1] <= pay1;
		end
	end

	for (genvar j = 2; j < NS; j++) begin : g_div
		localparam int B = NS - 1 - j;
		logic [63:0] rx, sh, tr;
		logic        ge;
		always_comb begin
			rx = {{(64-NW){1'b0}}, rem_s[j-1]};
			sh = {32'd0, den_s[j-1]} << B;
			tr = rx - sh;
			ge = rx >= sh;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? tr[NW-1:0] : rem_s[j-1];
				den_s[j] <= den_s[j-1];
				quo_s[j] <= quo_s[j-1] | ({30'd0, ge} << B);
				pay_s[j] <= pay_s[j-1];
			end
		end
	end

	always_comb begin
		res   = pay_s[NS-1];
		res.q = quo_s[NS-1];
	end

endmodule

### rtl/core/rbi_merge.sv
// ----------------------------------------------------------------------------
// rbi_merge
// Picks the entry plane from the three lanes, walks the ray to it and tests
// the remaining coordinates against the box; an origin inside the box hits there.
// ----------------------------------------------------------------------------
module rbi_merge import rbi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      en,
	input  lane_res_t lane [LANES],
	output logic      hit,
	output fix_t      hit_x,
	output fix_t      hit_y,
	output fix_t      hit_z
);

	logic [30:0] tv [LANES];
	logic [30:0] tb;
	logic [1:0]  bi;
	logic        bv;

	logic [30:0] tb_s1;
	logic [1:0]  best_s1;
	logic        bv_s1;
	logic        inside_s1;
	lane_res_t   lane_s1 [LANES];

	logic signed [63:0] prod_s2 [LANES];
	logic [1:0]         best_s2;
	logic               bv_s2;
	logic               inside_s2;
	lane_res_t          lane_s2 [LANES];

	always_comb begin
		for (int a = 0; a < LANES; a++) begin
			tv[a] = lane[a].ovf ? 31'h7FFF_FFFF : lane[a].q;
		end
		bv = lane[0].pos;
		bi = 2'd0;
		tb = tv[0];
		// strict compare keeps the lower axis on ties
		for (int a = 1; a < LANES; a++) begin
			if (lane[a].pos && (!bv || tv[a] > tb)) begin
				bv = 1'b1;
				bi = 2'(a);
				tb = tv[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tb_s1     <= tb;
			best_s1   <= bi;
			bv_s1     <= bv;
			inside_s1 <= !(lane[0].cand || lane[1].cand || lane[2].cand);
			lane_s1   <= lane;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < LANES; a++) begin
				prod_s2[a] <= $signed({1'b0, tb_s1}) * $signed(lane_s1[a].dir);
			end
			best_s2   <= best_s1;
			bv_s2     <= bv_s1;
			inside_s2 <= inside_s1;
			lane_s2   <= lane_s1;
		end
	end

	logic signed [63:0] crd [LANES];
	logic [LANES-1:0]   inr;
	logic               hit_n;
	logic [31:0]        pt [LANES];

	always_comb begin
		for (int a = 0; a < LANES; a++) begin
			crd[a] = $signed({{32{lane_s2[a].org[31]}}, lane_s2[a].org})
				+ (prod_s2[a] >>> FRAC_BITS);
			inr[a] = (best_s2 == 2'(a))
				|| ((crd[a] >= $signed({{32{lane_s2[a].lo[31]}}, lane_s2[a].lo}))
				&& (crd[a] <= $signed({{32{lane_s2[a].hi[31]}}, lane_s2[a].hi})));
		end
		hit_n = inside_s2 || (bv_s2 && (&inr));
		for (int a = 0; a < LANES; a++) begin
			if (inside_s2) begin
				pt[a] = lane_s2[a].org;
			end else if (!hit_n) begin
				pt[a] = 32'd0;
			end else if (best_s2 == 2'(a)) begin
				pt[a] = lane_s2[a].plane;
			end else begin
				pt[a] = crd[a][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit   <= hit_n;
			hit_x <= pt[0];
			hit_y <= pt[1];
			hit_z <= pt[2];
		end
	end

endmodule
